[rtl/core/rbt_pkg.sv]
package rbt_pkg;

	localparam int TimeW = 63;
	localparam int CountW = 16;
	localparam int SeedW = 32;
	localparam int CfgW = 63;
	localparam int IdxW = 3;
	localparam int StatusW = 2;
	localparam int SkipLimit = 64;

	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
	localparam logic [TimeW-1:0] DayNs = 63'd86400000000000;
	localparam logic [SeedW-1:0] LfsrTaps = 32'h80200003;

	typedef enum logic [IdxW-1:0] {
		REG_IRT = 3'd0,
		REG_MRT = 3'd1,
		REG_MRC = 3'd2,
		REG_MRD = 3'd3,
		REG_SEED = 3'd4
	} reg_idx_t;

	typedef enum logic [StatusW-1:0] {
		ST_CONTINUE = 2'd0,
		ST_MAX_COUNT = 2'd1,
		ST_MAX_DURATION = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_END_MUL,
		S_START_DRAW,
		S_RETRY_CHECK,
		S_RETRY_DRAW,
		S_RETRY_CAP,
		S_RETRY_ADV,
		S_CAP_END,
		S_DONE
	} state_t;

	// one serial multiply: operand times multiplier, bit by bit
	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_COUNT
	} mul_kind_t;

endpackage

[rtl/core/retransmit_backoff_timer_unit.sv]
// Work per item: a start item runs one serial multiply for the jittered interval (none when
// MRC is 1), after one for the end time when that is MRT*MRC; a retry item runs one per
// catch-up pass (two when the interval hits MRT), up to 64 passes, and none when a limit is
// hit. A serial shift-add multiplier, one multiplier bit per cycle, does each multiply.
// Throughput: one item at a time; the next item is accepted once the result is taken.
// Reset (arst_n low): all but the multiplier data registers clear; the LFSR loads 1, timer state 0.
module retransmit_backoff_timer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rbt_pkg::IdxW-1:0]    cfg_index,
	input  logic [rbt_pkg::CfgW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [rbt_pkg::TimeW-1:0]   now,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rbt_pkg::StatusW-1:0] status,
	output logic [rbt_pkg::TimeW-1:0]   next_time,
	output logic [rbt_pkg::TimeW-1:0]   interval,
	output logic [rbt_pkg::CountW-1:0]  attempt
);
	import rbt_pkg::*;

	localparam int MulW = 34;
	localparam int AccW = TimeW + MulW;
	localparam int MulCntW = $clog2(MulW + 1);
	localparam int PassW = $clog2(SkipLimit + 1);

	// configuration
	logic [TimeW-1:0] irt_q, mrt_q, mrd_q;
	logic [CountW-1:0] mrc_q;
	logic [SeedW-1:0] lfsr_q;

	// timer state
	logic [CountW-1:0] count_q;
	logic [TimeW-1:0] end_q, next_q, ivl_q;
	logic [StatusW-1:0] rstate_q;

	// item in flight
	logic req_q;
	logic [TimeW-1:0] now_q;
	logic [PassW-1:0] pass_q;
	logic capped_q;

	// serial multiplier
	logic [AccW-1:0] mop_q;
	logic [MulW-1:0] mer_q;
	logic [AccW-1:0] macc_q;
	logic [MulCntW-1:0] mcnt_q;
	logic mbusy_q;
	logic mstart;
	logic [TimeW-1:0] mstart_op;
	logic [MulW-1:0] mstart_mer;
	logic [MulCntW-1:0] mstart_cnt;

	state_t state_q, state_d;

	// jitter draw
	logic [SeedW-1:0] lfsr_nx;
	logic [SeedW-1:0] seed_in;
	logic [SeedW-1:0] lfsr_src;
	logic [SeedW-1:0] lfsr_ahead;
	logic [MulW-1:0] scale1, scale2;
	logic [SeedW-1:0] dev;
	logic [63:0] dev_prod;
	logic dev_up_q;
	logic [SeedW-1:0] dev5_q;

	// product results: floor(acc / 2^32) saturated, and acc itself saturated
	logic [TimeW-1:0] mres;
	logic [TimeW-1:0] msum_res;

	// saturating add helper
	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
			input logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? TimeMax : s[TimeW-1:0];
	endfunction

	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LfsrTaps) : (lfsr_q >> 1);
	assign seed_in = (cfg_data[SeedW-1:0] == '0) ? 32'd1 : cfg_data[SeedW-1:0];

	// precompute the deviation of the next draw; draws are never on consecutive cycles
	assign lfsr_src = (cfg_we && cfg_index == REG_SEED) ? seed_in : lfsr_q;
	assign lfsr_ahead = lfsr_src[0] ? ((lfsr_src >> 1) ^ LfsrTaps) : (lfsr_src >> 1);

	// (r - 2^31)/5 truncated toward zero, by magnitude
	assign dev = lfsr_ahead[31] ? {1'b0, lfsr_ahead[30:0]} : (32'h80000000 - lfsr_ahead);
	// divide by 5 as floor(x * 0xCCCCCCCD / 2^34), exact for any 32-bit x
	assign dev_prod = {32'd0, dev} * 64'h00000000CCCCCCCD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_up_q <= 1'b0;
			dev5_q <= '0;
		end else begin
			dev_up_q <= lfsr_ahead[31];
			dev5_q <= {2'b00, dev_prod[63:34]};
		end
	end

	always_comb begin
		if (dev_up_q) begin
			scale1 = 34'h100000000 + {2'b00, dev5_q};
			scale2 = 34'h200000000 + {2'b00, dev5_q};
		end else begin
			scale1 = 34'h100000000 - {2'b00, dev5_q};
			scale2 = 34'h200000000 - {2'b00, dev5_q};
		end
	end

	assign mres = (|macc_q[AccW-1:TimeW+32]) ? TimeMax : macc_q[TimeW+31:32];
	assign msum_res = (|macc_q[AccW-1:TimeW]) ? TimeMax : macc_q[TimeW-1:0];

	// retry checks
	logic cnt_hit;
	logic [TimeW-1:0] rt_new, next_new;
	assign cnt_hit = (mrc_q != '0) && (count_q >= mrc_q);
	assign rt_new = mres;
	assign next_new = sat_add(next_q, rt_new);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = rstate_q;
	assign next_time = next_q;
	assign interval = ivl_q;
	assign attempt = count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_START;
			S_START: begin
				if (!req_q) begin
					if (mrd_q == '0 && mrc_q != '0) state_d = S_END_MUL;
					else if (mrc_q == 16'd1) state_d = S_DONE;
					else state_d = S_START_DRAW;
				end else if (cnt_hit) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RETRY_CHECK;
				end
			end
			S_END_MUL: if (!mbusy_q) state_d = (mrc_q == 16'd1) ? S_DONE : S_START_DRAW;
			S_START_DRAW: if (!mbusy_q) state_d = S_CAP_END;
			S_RETRY_CHECK: state_d = (now_q >= end_q) ? S_DONE : S_RETRY_DRAW;
			S_RETRY_DRAW: begin
				if (!mbusy_q) begin
					if (mrt_q != '0 && rt_new > mrt_q && !capped_q) state_d = S_RETRY_CAP;
					else state_d = S_RETRY_ADV;
				end
			end
			S_RETRY_CAP: state_d = S_RETRY_DRAW;
			// repeat while next + rt/2 is still behind now and the pass limit is not reached
			S_RETRY_ADV: begin
				if (sat_add(next_q, ivl_q >> 1) < now_q && pass_q < PassW'(SkipLimit))
					state_d = S_RETRY_CHECK;
				else
					state_d = S_CAP_END;
			end
			S_CAP_END: state_d = S_DONE;
			S_DONE: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// multiplier launch
	always_comb begin
		mstart = 1'b0;
		mstart_op = ivl_q;
		mstart_mer = scale2;
		mstart_cnt = MulCntW'(MulW);
		case (state_q)
			S_START: begin
				if (!req_q && mrd_q == '0 && mrc_q != '0) begin
					mstart = 1'b1;
					mstart_op = mrt_q;
					mstart_mer = MulW'(mrc_q);
					mstart_cnt = MulCntW'(CountW);
				end else if (!req_q && mrc_q != 16'd1) begin
					mstart = 1'b1;
					mstart_op = irt_q;
					mstart_mer = scale1;
				end else if (req_q && !cnt_hit) begin
					mstart = 1'b0;
				end
			end
			S_END_MUL: begin
				if (!mbusy_q && mrc_q != 16'd1) begin
					mstart = 1'b1;
					mstart_op = irt_q;
					mstart_mer = scale1;
				end
			end
			S_RETRY_CHECK: begin
				if (now_q < end_q) begin
					mstart = 1'b1;
					mstart_op = ivl_q;
					mstart_mer = scale2;
				end
			end
			S_RETRY_CAP: begin
				mstart = 1'b1;
				mstart_op = mrt_q;
				mstart_mer = scale1;
			end
			default: mstart = 1'b0;
		endcase
	end

	// shift-add multiplier, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q <= '0;
		end else if (mstart) begin
			mbusy_q <= 1'b1;
			mcnt_q <= mstart_cnt;
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q - MulCntW'(1);
			if (mcnt_q == MulCntW'(1)) mbusy_q <= 1'b0;
		end
	end

	// operand shifts up one place per multiplier bit
	always_ff @(posedge clk) begin
		if (mstart) begin
			mop_q <= AccW'(mstart_op);
			mer_q <= mstart_mer;
			macc_q <= '0;
		end else if (mbusy_q) begin
			mer_q <= mer_q >> 1;
			mop_q <= mop_q << 1;
			if (mer_q[0]) macc_q <= macc_q + mop_q;
		end
	end

	// configuration, LFSR and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irt_q <= '0;
			mrt_q <= '0;
			mrc_q <= '0;
			mrd_q <= '0;
			lfsr_q <= 32'd1;
			count_q <= '0;
			end_q <= '0;
			next_q <= '0;
			ivl_q <= '0;
			rstate_q <= ST_CONTINUE;
			state_q <= S_IDLE;
			req_q <= 1'b0;
			now_q <= '0;
			pass_q <= '0;
			capped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_IRT: irt_q <= cfg_data;
					REG_MRT: mrt_q <= cfg_data;
					REG_MRC: mrc_q <= cfg_data[CountW-1:0];
					REG_MRD: mrd_q <= cfg_data;
					default: ;
				endcase
			end
			// draw steps the LFSR whenever a jittered multiply launches; a seed write loads it
			if (mstart && mstart_cnt == MulCntW'(MulW)) lfsr_q <= lfsr_nx;
			else if (cfg_we && cfg_index == REG_SEED) lfsr_q <= seed_in;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						now_q <= now;
						pass_q <= '0;
						capped_q <= 1'b0;
					end
				end
				S_START: begin
					if (req_q && cnt_hit)
						rstate_q <= (mrc_q == 16'd1) ? ST_MAX_DURATION : ST_MAX_COUNT;
					else
						rstate_q <= ST_CONTINUE;
					if (!req_q) begin
						count_q <= 16'd1;
						if (mrd_q != '0) end_q <= sat_add(now_q, mrd_q);
						else if (mrc_q == '0) end_q <= sat_add(now_q, DayNs);
						if (mrc_q == 16'd1 && mrd_q != '0) begin
							next_q <= sat_add(now_q, mrd_q);
							ivl_q <= mrd_q;
						end
					end else begin
						if (count_q != 16'hFFFF) count_q <= count_q + 16'd1;
					end
				end
				S_END_MUL: begin
					if (!mbusy_q) begin
						end_q <= sat_add(now_q, msum_res);
						if (mrc_q == 16'd1) begin
							next_q <= sat_add(now_q, msum_res);
							ivl_q <= mrd_q;
						end
					end
				end
				S_START_DRAW: begin
					if (!mbusy_q) begin
						ivl_q <= mres;
						next_q <= sat_add(now_q, mres);
					end
				end
				S_RETRY_CHECK: begin
					capped_q <= 1'b0;
					if (now_q >= end_q) rstate_q <= ST_MAX_DURATION;
				end
				S_RETRY_CAP: capped_q <= 1'b1;
				S_RETRY_DRAW: begin
					if (!mbusy_q && !(mrt_q != '0 && rt_new > mrt_q && !capped_q)) begin
						ivl_q <= rt_new;
						next_q <= next_new;
						pass_q <= pass_q + PassW'(1);
					end
				end
				S_CAP_END: if (next_q > end_q) next_q <= end_q;
				default: ;
			endcase
		end
	end

	// output holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_time))
		else $error("result changed under stall");
	// no item taken while one is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("accept while busy");
	// catch-up passes stay bounded
	assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= PassW'(SkipLimit))
		else $error("pass count overrun");

endmodule

[dv/retransmit_backoff_timer_unit_test.sv]
`timescale 1ns / 100ps

module retransmit_backoff_timer_unit_test;
	import rbt_pkg::*;

	localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_DAY = 64'd86400000000000;
	localparam logic [63:0] SCALE_ONE = 64'h1_0000_0000;
	localparam logic [63:0] SCALE_TWO = 64'h2_0000_0000;
	localparam logic [63:0] SCALE_MID = 64'h8000_0000;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		status_t status;
		logic [TimeW-1:0] next_time;
		logic [TimeW-1:0] interval;
		logic [CountW-1:0] attempt;
	} timer_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic [TimeW-1:0] now;
	logic out_valid;
	logic out_stall;
	logic [StatusW-1:0] status;
	logic [TimeW-1:0] next_time;
	logic [TimeW-1:0] interval;
	logic [CountW-1:0] attempt;

	// predictor copy of registers and timer state
	logic [63:0] cfg_irt = 0, cfg_mrt = 0, cfg_mrd = 0;
	logic [15:0] cfg_mrc = 0;
	logic [31:0] cfg_seed = 1;
	logic [15:0] seq_count = 0;
	logic [63:0] seq_end = 0, seq_next = 0, seq_interval = 0;
	logic [31:0] jitter_state = 1;
	status_t last_status = ST_CONTINUE;

	timer_result_t expected_results[$];
	timer_result_t want;
	int n_errors = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit no_idle = 0;

	retransmit_backoff_timer_unit dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = a + b;
		return (s > T_MAX) ? T_MAX : s[63:0];
	endfunction

	// step the jitter LFSR and return the jittered scale
	function automatic logic [63:0] next_jitter_scale(logic [63:0] base);
		logic out_bit;
		logic [63:0] r;
		out_bit = jitter_state[0];
		jitter_state = jitter_state >> 1;
		if (out_bit)
			jitter_state ^= LfsrTaps;
		r = {32'd0, jitter_state};
		if (r >= SCALE_MID)
			return base + (r - SCALE_MID) / 5;
		return base - (SCALE_MID - r) / 5;
	endfunction

	function automatic logic [63:0] scaled(logic [63:0] scale, logic [63:0] x);
		logic [127:0] p;
		p = (128'(scale) * 128'(x)) >> 32;
		return (p > T_MAX) ? T_MAX : p[63:0];
	endfunction

	// advance the timer state by one item and return its result
	function automatic timer_result_t predict_timer(logic rtype, logic [TimeW-1:0] now_in);
		timer_result_t res;
		logic [63:0] t, rt;
		logic [127:0] prod;
		logic [15:0] old;
		status_t st;
		bit done;
		t = {1'b0, now_in};
		st = ST_CONTINUE;
		if (!rtype) begin
			seq_count = 1;
			if (cfg_mrd != 0)
				seq_end = sat_sum(t, cfg_mrd);
			else if (cfg_mrc == 0)
				seq_end = sat_sum(t, ONE_DAY);
			else begin
				prod = 128'(cfg_mrt) * 128'(cfg_mrc);
				seq_end = (prod > T_MAX) ? T_MAX : sat_sum(t, prod[63:0]);
			end
			if (cfg_mrc == 1) begin
				seq_next = seq_end;
				seq_interval = cfg_mrd;
			end else begin
				seq_interval = scaled(next_jitter_scale(SCALE_ONE), cfg_irt);
				seq_next = sat_sum(t, seq_interval);
				if (seq_next > seq_end)
					seq_next = seq_end;
			end
		end else begin
			old = seq_count;
			if (seq_count < 16'hFFFF)
				seq_count++;
			if (cfg_mrc != 0 && old >= cfg_mrc)
				st = (cfg_mrc == 1) ? ST_MAX_DURATION : ST_MAX_COUNT;
			else begin
				done = 0;
				for (int pass = 0; pass < SkipLimit && !done; pass++) begin
					if (t >= seq_end) begin
						st = ST_MAX_DURATION;
						done = 1;
					end else begin
						rt = scaled(next_jitter_scale(SCALE_TWO), seq_interval);
						if (cfg_mrt != 0 && rt > cfg_mrt)
							rt = scaled(next_jitter_scale(SCALE_ONE), cfg_mrt);
						seq_interval = rt;
						seq_next = sat_sum(seq_next, rt);
						if (!(sat_sum(seq_next, rt / 2) < t))
							done = 1;
					end
				end
				if (st == ST_CONTINUE && seq_next > seq_end)
					seq_next = seq_end;
			end
		end
		last_status = st;
		res.status = st;
		res.next_time = seq_next[TimeW-1:0];
		res.interval = seq_interval[TimeW-1:0];
		res.attempt = seq_count;
		return res;
	endfunction

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with none expected: status %0d next_time %0d", status, next_time);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_errors++;
				end
				if (next_time !== want.next_time) begin
					$error("next_time: expected %0d, got %0d", want.next_time, next_time);
					n_errors++;
				end
				if (interval !== want.interval) begin
					$error("interval: expected %0d, got %0d", want.interval, interval);
					n_errors++;
				end
				if (attempt !== want.attempt) begin
					$error("attempt: expected %0d, got %0d", want.attempt, attempt);
					n_errors++;
				end
			end
		end
	end

	// result side: draw a stall per item, or take a requested long hold
	initial begin
		int w;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end else
				w = no_idle ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				out_stall <= 1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// offer one item, wait for it to be taken, record its expected result
	task automatic send_item(logic rtype, logic [TimeW-1:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		req_type <= rtype;
		now <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(predict_timer(rtype, t));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write enable stays high across consecutive writes; the caller drops it
	task automatic write_reg(reg_idx_t idx, logic [CfgW-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		case (idx)
			REG_IRT: cfg_irt = {1'b0, v};
			REG_MRT: cfg_mrt = {1'b0, v};
			REG_MRC: cfg_mrc = v[15:0];
			REG_MRD: cfg_mrd = {1'b0, v};
			REG_SEED: begin
				cfg_seed = v[31:0];
				jitter_state = (cfg_seed == 0) ? 32'd1 : cfg_seed;
			end
			default: ;
		endcase
	endtask

	task automatic set_timer(logic [63:0] irt, logic [63:0] mrt, logic [15:0] mrc,
			logic [63:0] mrd, logic [31:0] seed);
		wait_idle();
		write_reg(REG_IRT, irt[62:0]);
		write_reg(REG_MRT, mrt[62:0]);
		write_reg(REG_MRC, {47'd0, mrc});
		write_reg(REG_MRD, mrd[62:0]);
		write_reg(REG_SEED, {31'd0, seed});
		cfg_we <= 0;
	endtask

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	// pick a retry time around the predicted due time
	function automatic logic [TimeW-1:0] retry_time();
		logic [63:0] t;
		case ($urandom_range(0, 19))
			0: t = (seq_next > 1000) ? seq_next - $urandom_range(1, 1000) : 64'd0;
			1: t = sat_sum(seq_next, sat_sum(seq_interval, seq_interval));
			2: t = wide_random() & T_MAX;
			3: t = seq_end;
			default: t = sat_sum(seq_next, wide_random() % (seq_interval / 4 + 1));
		endcase
		return t[TimeW-1:0];
	endfunction

	// retry before any start, then the all-zero defaults
	task automatic test_idle_defaults();
		send_item(1, 63'd0);
		send_item(0, 63'd0);
		send_item(1, 63'd5);
	endtask

	task automatic test_count_limit();
		set_timer(1000, 100000, 3, 0, 32'h1234_5678);
		send_item(0, 63'd100);
		repeat (3) send_item(1, seq_next[TimeW-1:0]);
		send_item(1, seq_next[TimeW-1:0]);
	endtask

	task automatic test_single_shot();
		set_timer(1000, 0, 1, 5000, 32'hDEAD_BEEF);
		send_item(0, 63'd7);
		send_item(1, 63'd10);
	endtask

	// duration expiry and the interval cap
	task automatic test_duration_limit();
		set_timer(1000, 1500, 0, 3000, 32'h0F0F_0F0F);
		send_item(0, 63'd0);
		send_item(1, seq_next[TimeW-1:0]);
		send_item(1, seq_next[TimeW-1:0]);
		send_item(1, 63'd3000);
	endtask

	task automatic test_extremes();
		set_timer(T_MAX, T_MAX, 16'hFFFF, 0, 32'd0);
		send_item(0, T_MAX[TimeW-1:0]);
		send_item(1, T_MAX[TimeW-1:0]);
		send_item(0, 63'd0);
		send_item(1, 63'd1);
		set_timer(T_MAX, 0, 0, T_MAX, 32'hFFFF_FFFF);
		send_item(0, T_MAX[TimeW-1:0] - 63'd5);
		send_item(0, 63'd0);
		send_item(1, 63'd1);
	endtask

	// hold the result side off while items keep coming, then drain
	task automatic test_backpressure();
		set_timer(50000, 400000, 0, 0, $urandom);
		no_idle = 1;
		hold_cycles = 400;
		send_item(0, 63'd1000);
		repeat (9) send_item(1, retry_time());
		no_idle = 0;
		wait_idle();
	endtask

	task automatic test_random_sequences(int total);
		int sent;
		int phase_items;
		int retries;
		logic [63:0] irt, mrt, mrd;
		logic [15:0] mrc;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(0, 5))
				0: irt = 0;
				1: irt = wide_random() & T_MAX;
				default: irt = 64'($urandom_range(1, 1000000)) * $urandom_range(1, 1000);
			endcase
			case ($urandom_range(0, 3))
				0: mrt = 0;
				1: mrt = wide_random() & T_MAX;
				default: mrt = sat_sum(irt, irt * $urandom_range(1, 30));
			endcase
			case ($urandom_range(0, 5))
				0: mrc = 0;
				1: mrc = 1;
				2: mrc = 16'hFFFF;
				default: mrc = $urandom_range(2, 12);
			endcase
			case ($urandom_range(0, 3))
				0: mrd = wide_random() & T_MAX;
				1: mrd = sat_sum(irt, irt) * $urandom_range(1, 64);
				default: mrd = 0;
			endcase
			set_timer(irt, mrt, mrc, mrd & T_MAX, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom);
			no_idle = ($urandom_range(0, 3) == 0);
			phase_items = $urandom_range(40, 80);
			while (phase_items > 0) begin
				if ($urandom_range(0, 7) == 0)
					send_item(0, wide_random() & T_MAX);
				else
					send_item(0, 64'($urandom) * $urandom_range(1, 1000));
				phase_items--;
				sent++;
				retries = $urandom_range(1, 12);
				while (retries > 0 && phase_items > 0) begin
					if ($urandom_range(0, 9) == 0)
						send_item($urandom_range(0, 1), wide_random() & T_MAX);
					else
						send_item(1, retry_time());
					retries--;
					phase_items--;
					sent++;
					if (last_status != ST_CONTINUE && $urandom_range(0, 1) == 0)
						retries = 0;
				end
			end
			no_idle = 0;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_IRT;
		cfg_data = 0;
		in_valid = 0;
		req_type = 0;
		now = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_idle_defaults();
		test_count_limit();
		test_single_shot();
		test_duration_limit();
		test_extremes();
		test_backpressure();
		test_random_sequences(480);

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
